>>> rtl/core/cmos_rtc_register_file_assert.svh
// ----------------------------------------------------------------------------
// CMOS RTC register file assertion macros
// Shared assertion forms used by the register file core.
// ----------------------------------------------------------------------------
`ifndef CMOS_RTC_REGISTER_FILE_ASSERT_SVH
`define CMOS_RTC_REGISTER_FILE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmos rtc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CRF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmos rtc assertion failed");

`endif

>>> rtl/core/crf_pkg.sv
// ----------------------------------------------------------------------------
// CMOS RTC register file package
// Register indexes, fixed values, request layout and BCD conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package crf_pkg;

   localparam int RamWidth = 41;

   typedef logic [6:0] reg_index_type;

   localparam reg_index_type REG_SECONDS   = 7'h00;
   localparam reg_index_type REG_SEC_ALARM = 7'h01;
   localparam reg_index_type REG_MINUTES   = 7'h02;
   localparam reg_index_type REG_MIN_ALARM = 7'h03;
   localparam reg_index_type REG_HOURS     = 7'h04;
   localparam reg_index_type REG_HR_ALARM  = 7'h05;
   localparam reg_index_type REG_DAY       = 7'h07;
   localparam reg_index_type REG_MONTH     = 7'h08;
   localparam reg_index_type REG_YEAR      = 7'h09;
   localparam reg_index_type REG_STATUS_A  = 7'h0A;
   localparam reg_index_type REG_STATUS_B  = 7'h0B;
   localparam reg_index_type REG_STATUS_C  = 7'h0C;
   localparam reg_index_type REG_STATUS_D  = 7'h0D;
   localparam reg_index_type REG_RESET     = 7'h0F;
   localparam reg_index_type REG_FLOPPY    = 7'h10;
   localparam reg_index_type REG_DISK      = 7'h12;
   localparam reg_index_type REG_EQUIP_13  = 7'h13;
   localparam reg_index_type REG_EXT_17    = 7'h17;
   localparam reg_index_type REG_EXT_18    = 7'h18;
   localparam reg_index_type REG_CENTURY   = 7'h32;
   localparam reg_index_type REG_MEM_LO    = 7'h34;
   localparam reg_index_type REG_MEM_HI    = 7'h35;
   localparam reg_index_type REG_BOOT_38   = 7'h38;
   localparam reg_index_type REG_BOOT_39   = 7'h39;
   localparam reg_index_type REG_BOOT_3D   = 7'h3D;
   localparam reg_index_type REG_HIGH_0    = 7'h5B;
   localparam reg_index_type REG_HIGH_1    = 7'h5C;
   localparam reg_index_type REG_HIGH_2    = 7'h5D;
   localparam reg_index_type REG_HIGH_3    = 7'h5F;

   localparam logic [7:0] STATUS_A_VALUE = 8'h26;
   localparam logic [7:0] STATUS_D_VALUE = 8'h80;
   localparam logic [7:0] FLOPPY_VALUE   = 8'h40;
   localparam logic [7:0] DISK_VALUE     = 8'hF0;
   localparam logic [7:0] PM_FLAG        = 8'h80;
   localparam logic [7:0] UNKNOWN_VALUE  = 8'hFF;

   localparam logic [RamWidth-1:0] EXT_TOP   = 41'h0_E000_0000;
   localparam logic [RamWidth-1:0] HOLE_SIZE = 41'h0_0010_0000;
   localparam logic [RamWidth-1:0] HIGH_BASE = EXT_TOP + HOLE_SIZE;
   localparam logic [31:0]         LOW_16M   = 32'h0100_0000;

   localparam int BinaryBit = 2;
   localparam int Hour24Bit = 1;

   typedef struct packed {
      logic [7:0] now_year;
      logic [3:0] now_month;
      logic [4:0] now_day;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
      logic [5:0] now_second;
      logic [7:0] write_data;
   } req_fields_type;

   function automatic logic [7:0] to_reg(input logic [7:0] v, input logic binary);
      logic [15:0] prod;
      logic [4:0]  tens;
      logic [7:0]  ones;
      prod = 16'(v) * 16'd205;
      tens = prod[15:11];
      ones = v - 8'(tens) * 8'd10;
      if (binary) begin
         return v;
      end
      return {tens[3:0], ones[3:0]};
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/cmos_rtc_register_file.sv
// ----------------------------------------------------------------------------
// CMOS RTC register file
// Index and data port model of a PC real-time clock and CMOS memory.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | tuser: req_type, port_sel; tdata: byte and time fields
//  rsp_    | out       | tdata: read_data; tuser: bad_access
//  csr_    | in        | data: ram_size, always ready
//
//  Each accepted item has its result registered in the cycle after acceptance.
//  One item is accepted every cycle while the result register drains.
//  Reset clears the index, status B, the reset code and the memory size.
//  A stalled result holds the output register and blocks new items.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cmos_rtc_register_file_assert.svh"

module cmos_rtc_register_file
   import crf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // write_data[7:0], now_second[13:8], now_minute[19:14], now_hour[24:20],
   // now_day[29:25], now_month[33:30], now_year[41:34], zero[47:42]
   input  wire logic [47:0]         req_tdata,
   // req_type[0], port_sel[1]
   input  wire logic [1:0]          req_tuser,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // read_data[7:0]
   output logic [7:0]               rsp_tdata,
   // bad_access[0]
   output logic                     rsp_tuser,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [RamWidth-1:0] csr_data
);

   req_fields_type req;
   logic           req_accept;
   logic           is_write;
   logic           data_port;

   reg_index_type  index_ff, index_in;
   logic [7:0]     status_b_ff, status_b_in;
   logic [7:0]     reset_code_ff, reset_code_in;
   logic [15:0]    ext_mem_ff, ext_mem_in;
   logic [23:0]    high_mem_ff, high_mem_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   logic           rsp_bad_ff, rsp_bad_in;

   logic [31:0]         ext_base;
   logic [31:0]         ext_full;
   logic [RamWidth-1:0] high_full;

   logic [7:0] read_value;
   logic       read_bad;
   logic       write_bad;
   logic       binary;
   logic [7:0] hour8;
   logic [7:0] year8;

   assign req              = req_fields_type'(req_tdata[41:0]);
   assign is_write         = req_tuser[0];
   assign data_port        = req_tuser[1];
   assign req_tready       = !rsp_valid_ff || rsp_tready;
   assign req_accept       = req_tvalid && req_tready;
   assign csr_ready        = 1'b1;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;
   assign rsp_tuser        = rsp_bad_ff;
   assign binary           = status_b_ff[BinaryBit];

   always_comb begin
      ext_base    = (csr_data > EXT_TOP) ? EXT_TOP[31:0] : csr_data[31:0];
      ext_full    = (ext_base > LOW_16M) ? ext_base - LOW_16M : 32'd0;
      high_full   = (csr_data > HIGH_BASE) ? csr_data - HIGH_BASE : '0;
      ext_mem_in  = ext_mem_ff;
      high_mem_in = high_mem_ff;
      if (csr_valid) begin
         ext_mem_in  = ext_full[31:16];
         high_mem_in = high_full[39:16];
      end
   end

   always_comb begin
      hour8 = {3'b000, req.now_hour};
      year8 = (req.now_year >= 8'd100) ? req.now_year - 8'd100 : req.now_year;
      read_bad   = 1'b0;
      read_value = UNKNOWN_VALUE;
      unique case (index_ff) inside
         REG_SECONDS: read_value = to_reg({2'b00, req.now_second}, binary);
         REG_MINUTES: read_value = to_reg({2'b00, req.now_minute}, binary);
         REG_HOURS: begin
            if (!status_b_ff[Hour24Bit] && hour8 == 8'd0) begin
               read_value = to_reg(8'd12, binary);
            end else if (!status_b_ff[Hour24Bit] && hour8 == 8'd12) begin
               read_value = PM_FLAG | to_reg(8'd12, binary);
            end else if (!status_b_ff[Hour24Bit] && hour8 > 8'd12) begin
               read_value = PM_FLAG | to_reg(hour8 - 8'd12, binary);
            end else begin
               read_value = to_reg(hour8, binary);
            end
         end
         REG_DAY:      read_value = to_reg({3'b000, req.now_day}, binary);
         REG_MONTH:    read_value = to_reg({4'b0000, req.now_month}, binary);
         REG_YEAR:     read_value = to_reg(year8, binary);
         REG_STATUS_A: read_value = STATUS_A_VALUE;
         REG_STATUS_B: read_value = status_b_ff;
         REG_STATUS_C: read_value = 8'h00;
         REG_STATUS_D: read_value = STATUS_D_VALUE;
         REG_RESET:    read_value = reset_code_ff;
         REG_FLOPPY:   read_value = FLOPPY_VALUE;
         REG_DISK:     read_value = DISK_VALUE;
         REG_EQUIP_13: read_value = 8'h00;
         REG_CENTURY: begin
            read_value = to_reg({7'd0, req.now_year >= 8'd100}, binary);
         end
         REG_MEM_LO:   read_value = ext_mem_ff[7:0];
         REG_MEM_HI:   read_value = ext_mem_ff[15:8];
         REG_BOOT_38,
         REG_BOOT_39:  read_value = 8'h01;
         REG_BOOT_3D:  read_value = 8'h02;
         REG_HIGH_0:   read_value = high_mem_ff[7:0];
         REG_HIGH_1:   read_value = high_mem_ff[15:8];
         REG_HIGH_2:   read_value = high_mem_ff[23:16];
         REG_HIGH_3:   read_value = 8'h00;
         REG_SEC_ALARM, REG_MIN_ALARM, REG_HR_ALARM,
         REG_EXT_17, REG_EXT_18: read_value = UNKNOWN_VALUE;
         default: begin
            read_value = UNKNOWN_VALUE;
            read_bad   = 1'b1;
         end
      endcase
   end

   always_comb begin
      write_bad = 1'b1;
      unique case (index_ff) inside
         REG_STATUS_A: begin
            write_bad = (req.write_data[3:0] != 4'h6) || (req.write_data[6:4] != 3'h2);
         end
         REG_STATUS_B, REG_RESET, REG_SECONDS, REG_MINUTES, REG_HOURS,
         REG_DAY, REG_MONTH, REG_YEAR, REG_EXT_17, REG_CENTURY: write_bad = 1'b0;
         default: write_bad = 1'b1;
      endcase
   end

   always_comb begin
      index_in      = index_ff;
      status_b_in   = status_b_ff;
      reset_code_in = reset_code_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_bad_in    = rsp_bad_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = 8'h00;
         rsp_bad_in   = 1'b0;
         if (is_write && !data_port) begin
            index_in = req.write_data[6:0];
         end else if (is_write) begin
            rsp_bad_in = write_bad;
            if (index_ff == REG_STATUS_B) begin
               status_b_in = req.write_data;
            end
            if (index_ff == REG_RESET) begin
               reset_code_in = req.write_data;
            end
         end else if (!data_port) begin
            rsp_data_in = {1'b0, index_ff};
         end else begin
            rsp_data_in = read_value;
            rsp_bad_in  = read_bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff      <= '0;
         status_b_ff   <= '0;
         reset_code_ff <= '0;
         ext_mem_ff    <= '0;
         high_mem_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         index_ff      <= index_in;
         status_b_ff   <= status_b_in;
         reset_code_ff <= reset_code_in;
         ext_mem_ff    <= ext_mem_in;
         high_mem_ff   <= high_mem_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   `CRF_ASSERT_SAME(a_stall_blocks, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `CRF_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_accept, rsp_tvalid)
   `CRF_ASSERT_NEXT(a_index_write, clock, reset, req_accept && is_write && !data_port,
                    index_ff == $past(req_tdata[6:0]))
   `CRF_ASSERT_NEXT(a_write_reads_zero, clock, reset, req_accept && is_write,
                    rsp_tdata == 8'h00)

endmodule

`default_nettype wire
